[rtl/core/lsf_pkg.sv]
// lsf_pkg: shared types, codes and defaults for the line substring filter.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps

package lsf_pkg;

    localparam int LINE_LENGTH_DEF = 256;
    localparam int MAX_LINES_DEF   = 256;
    localparam int MAX_PATTERN_DEF = 8;

    localparam int PAT_W     = 64;
    localparam int PLEN_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W     = 9;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;

    // Result status codes
    localparam logic [1:0] ST_LINE_DONE = 2'd0;
    localparam logic [1:0] ST_TOO_LONG  = 2'd1;
    localparam logic [1:0] ST_END       = 2'd2;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       status;
        logic             line_matched;
        logic [IDX_W-1:0] line_index;
    } t_out_word;

    // Control broadcast to every window cell
    typedef struct packed {
        logic              shift;
        logic              clear;
        logic [PLEN_W-1:0] len;
    } t_cell_ctl;

endpackage

[rtl/core/lsf_cell.sv]
// lsf_cell: one position of the sliding byte window, with its pattern compare.
// Depends on lsf_pkg.
`timescale 1ns / 1ps

module lsf_cell
    import lsf_pkg::*;
#(
    parameter int POS = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [PAT_W-1:0] i_pattern,
    input  logic [7:0]       i_byte,
    input  logic             i_valid,
    output logic [7:0]       o_byte,
    output logic             o_valid,
    output logic             o_hit
);

    logic [7:0]        r_byte;
    logic              r_valid;
    logic [PLEN_W-1:0] sel_idx;
    logic [7:0]        want;

    // This cell holds window position POS after the shift; it must equal
    // pattern byte len-1-POS.
    assign sel_idx = i_ctl.len - PLEN_W'(POS) - PLEN_W'(1);
    assign want    = i_pattern[{sel_idx[2:0], 3'b000} +: 8];
    assign o_hit   = (PLEN_W'(POS) >= i_ctl.len) || (i_valid && (i_byte == want));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte  = r_byte;
    assign o_valid = r_valid;

endmodule

[rtl/core/lsf_out_stage.sv]
// lsf_out_stage: result register between the window logic and the consumer.
// Depends on lsf_pkg.
`timescale 1ns / 1ps

module lsf_out_stage
    import lsf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_word i_word,
    output logic      o_free,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);

    logic      r_valid;
    t_out_word r_word;

    // Free when empty or when the held word leaves this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

[rtl/core/line_substring_filter.sv]
// line_substring_filter: top level, line tracking and result generation.
// Depends on lsf_pkg, lsf_cell and lsf_out_stage.
`timescale 1ns / 1ps

// Streams text one byte per word and reports, per newline-ended line, whether
// the configured pattern (up to MAX_PATTERN bytes) occurs in it. A line that
// reaches LINE_LENGTH bytes is reported as too long and dropped; an end of
// input word reports end and stops the block, as does reaching MAX_LINES line
// results. Once stopped, words are still taken but give nothing until reset.
// Throughput is one word per cycle unless input is held: the window is a row
// of MAX_PATTERN cells that shift in every accepted byte other than a newline
// or end of input and compare their incoming bytes against the pattern in
// parallel, so the line state updates in the same cycle. Input is held only
// while a result waits in the output register and the consumer is not ready.
// No clearing pass after reset. Write configuration only while idle.

module line_substring_filter
    import lsf_pkg::*;
#(
    parameter int LINE_LENGTH = LINE_LENGTH_DEF,
    parameter int MAX_LINES   = MAX_LINES_DEF,
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // text words
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_data,
    // result words
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_data,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PAT_W-1:0]     i_cfg_data
);

    localparam int CNT_W  = $clog2(LINE_LENGTH + 1);
    localparam int LINE_W = $clog2(MAX_LINES + 1);

    // Configuration registers
    logic [PAT_W-1:0]  r_pattern;
    logic [PLEN_W-1:0] r_pat_len;
    logic [PLEN_W-1:0] len_sat;

    // Line state
    logic [CNT_W-1:0]  r_count,   n_count;
    logic              r_found,   n_found;
    logic [LINE_W-1:0] r_lines,   n_lines;
    logic              r_stopped, n_stopped;

    logic              in_fire;
    logic              out_free;
    logic              out_load;
    t_out_word         out_word;
    t_cell_ctl         cell_ctl;
    logic              match_now;
    logic [CNT_W-1:0]  count_inc;
    logic [LINE_W-1:0] lines_inc;

    // Window row: cell 0 takes the new byte, each cell feeds the next
    logic [MAX_PATTERN:0][7:0] chain_byte;
    logic [MAX_PATTERN:0]      chain_valid;
    logic [MAX_PATTERN-1:0]    cell_hit;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = out_free;
    assign in_fire     = i_in_valid && o_in_ready;

    // Hold configuration; ignore indexes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_pat_len <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PATTERN_BYTES:  r_pattern <= i_cfg_data;
                REG_PATTERN_LENGTH: r_pat_len <= i_cfg_data[PLEN_W-1:0];
                default:            ;
            endcase
        end
    end

    // Saturate the pattern length to the number of cells
    assign len_sat = (r_pat_len > PLEN_W'(MAX_PATTERN)) ? PLEN_W'(MAX_PATTERN) : r_pat_len;

    assign chain_byte[0]  = i_in_data.char_byte;
    assign chain_valid[0] = 1'b1;

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        lsf_cell #(
            .POS (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (cell_ctl),
            .i_pattern (r_pattern),
            .i_byte    (chain_byte[g]),
            .i_valid   (chain_valid[g]),
            .o_byte    (chain_byte[g+1]),
            .o_valid   (chain_valid[g+1]),
            .o_hit     (cell_hit[g])
        );
    end

    // Pattern present in the window once the new byte is shifted in
    assign match_now = (len_sat != '0) && (&cell_hit);
    assign count_inc = r_count + CNT_W'(1);
    assign lines_inc = r_lines + LINE_W'(1);

    always_comb begin
        n_count   = r_count;
        n_found   = r_found;
        n_lines   = r_lines;
        n_stopped = r_stopped;
        out_load  = 1'b0;
        out_word  = '{status: ST_LINE_DONE, line_matched: 1'b0,
                      line_index: IDX_W'(r_lines)};
        cell_ctl  = '{shift: 1'b0, clear: 1'b0, len: len_sat};

        if (in_fire && !r_stopped) begin
            if (i_in_data.end_of_input) begin
                // Drop the partial line, report end and stop
                out_load       = 1'b1;
                out_word.status = ST_END;
                cell_ctl.clear = 1'b1;
                n_count        = '0;
                n_found        = 1'b0;
                n_stopped      = 1'b1;
            end else if (i_in_data.char_byte == NEWLINE_BYTE) begin
                out_load              = 1'b1;
                out_word.status       = ST_LINE_DONE;
                out_word.line_matched = r_found;
                cell_ctl.clear        = 1'b1;
                n_count               = '0;
                n_found               = 1'b0;
                n_lines               = lines_inc;
                n_stopped             = (lines_inc >= LINE_W'(MAX_LINES));
            end else begin
                cell_ctl.shift = 1'b1;
                if (count_inc >= CNT_W'(LINE_LENGTH)) begin
                    // Line too long: report and drop it
                    out_load        = 1'b1;
                    out_word.status = ST_TOO_LONG;
                    cell_ctl.clear  = 1'b1;
                    n_count         = '0;
                    n_found         = 1'b0;
                    n_lines         = lines_inc;
                    n_stopped       = (lines_inc >= LINE_W'(MAX_LINES));
                end else begin
                    n_count = count_inc;
                    n_found = r_found || match_now;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_found   <= 1'b0;
            r_lines   <= '0;
            r_stopped <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_found   <= n_found;
            r_lines   <= n_lines;
            r_stopped <= n_stopped;
        end
    end

    lsf_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_word  (out_word),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_data)
    );

    // A stopped block never produces a result
    a_no_result_when_stopped : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> !out_load)
        else $error("result produced while stopped");

    // Stop is sticky until reset
    a_stop_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stopped flag cleared without reset");

    // The line byte count is always below the line limit
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_W'(LINE_LENGTH))
        else $error("line byte count reached the line limit");

    // Filled window cells form a prefix of the row
    a_window_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((chain_valid[MAX_PATTERN:1] + MAX_PATTERN'(1)) & chain_valid[MAX_PATTERN:1]) == '0)
        else $error("window cell fill is not contiguous");

    // A match can only be recorded in a non-empty line
    a_found_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_count != '0))
        else $error("match flag set for an empty line");

endmodule

[dv/line_substring_filter_checker.sv]
// line_substring_filter_checker: watches the text, result and configuration channels,
// predicts every report and compares it. Depends on lsf_pkg.
`timescale 1ns / 1ps

module line_substring_filter_checker
    import lsf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_word             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_word            i_out_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PAT_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    logic [PAT_W-1:0]  pat_bytes;
    logic [PLEN_W-1:0] pat_len;

    logic [7:0]        window [8];     // newest byte of the line at 0
    int                chars_in_line;
    bit                found_in_line;
    logic [IDX_W-1:0]  lines_reported;
    bit                halted;

    t_out_word         line_reports_q [$];
    int                fail_total;

    function automatic bit window_hit();
        int eff;
        eff = (pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(pat_len);
        if (eff == 0 || chars_in_line < eff)
            return 1'b0;
        for (int k = 0; k < eff; k++)
            if (window[eff-1-k] != pat_bytes[8*k +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic clear_line();
        for (int i = 0; i < 8; i++)
            window[i] = 8'd0;
        chars_in_line = 0;
        found_in_line = 1'b0;
    endtask

    task automatic push_report(logic [1:0] st, logic hit);
        t_out_word r;
        r.status       = st;
        r.line_matched = hit;
        r.line_index   = lines_reported;
        line_reports_q.push_back(r);
    endtask

    // Report a finished or dropped line and count it toward the line limit.
    task automatic close_line(logic [1:0] st, logic hit);
        push_report(st, hit);
        clear_line();
        lines_reported++;
        if (lines_reported >= MAX_LINES_DEF)
            halted = 1'b1;
    endtask

    task automatic scan_word(t_in_word w);
        if (halted) begin
            // stopped until reset: take the word, report nothing
        end else if (w.end_of_input) begin
            push_report(ST_END, 1'b0);
            clear_line();
            halted = 1'b1;
        end else if (w.char_byte == NEWLINE_BYTE) begin
            close_line(ST_LINE_DONE, found_in_line);
        end else begin
            for (int i = 7; i > 0; i--)
                window[i] = window[i-1];
            window[0] = w.char_byte;
            chars_in_line++;
            if (window_hit())
                found_in_line = 1'b1;
            if (chars_in_line >= LINE_LENGTH_DEF)
                close_line(ST_TOO_LONG, 1'b0);
        end
    endtask

    task automatic log_failure(string msg);
        if (fail_total < 10)
            $display("%0t: %s", $time, msg);
        fail_total++;
    endtask

    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            pat_bytes      = '0;
            pat_len        = '0;
            lines_reported = '0;
            halted         = 1'b0;
            clear_line();
            line_reports_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_PATTERN_BYTES)
                    pat_bytes = i_cfg_data;
                else if (i_cfg_index == REG_PATTERN_LENGTH)
                    pat_len = i_cfg_data[PLEN_W-1:0];
            end
            if (i_out_valid && i_out_ready) begin
                if (line_reports_q.size() == 0) begin
                    log_failure($sformatf("unexpected report: status %0d matched %0b index %0d",
                        i_out_data.status, i_out_data.line_matched, i_out_data.line_index));
                end else begin
                    want = line_reports_q.pop_front();
                    if (want.status !== i_out_data.status
                            || want.line_matched !== i_out_data.line_matched
                            || want.line_index !== i_out_data.line_index)
                        log_failure($sformatf({"report mismatch: expected status %0d ",
                            "matched %0b index %0d, got status %0d matched %0b index %0d"},
                            want.status, want.line_matched, want.line_index,
                            i_out_data.status, i_out_data.line_matched,
                            i_out_data.line_index));
                end
            end
            if (i_in_valid && i_in_ready)
                scan_word(i_in_data);
        end
        o_pending    <= line_reports_q.size();
        o_fail_count <= fail_total;
    end

endmodule

[dv/line_substring_filter_tb.sv]
// line_substring_filter_tb: drives text words and pattern writes into the filter with
// random gaps and stalls, and gives the verdict. Depends on lsf_pkg and the checker.
`timescale 1ns / 1ps

module line_substring_filter_tb;
    import lsf_pkg::*;

    localparam int HALF_PERIOD       = 10;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int WORDS_PER_PHASE   = 80;
    localparam int HOLD_AT_RESULT    = 30;    // result count that starts the long hold
    localparam int LONG_HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES      = 8;

    // Indexes past the register list; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_word             in_data   = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PAT_W-1:0]     cfg_data  = '0;

    logic                 in_ready;
    logic                 out_valid;
    t_out_word            out_data;
    logic                 cfg_ready;

    int                   fail_count;
    int                   pending;

    // Stimulus bookkeeping: what the pattern is now and how many lines were closed.
    logic [PAT_W-1:0]     cur_pat   = '0;
    logic [PLEN_W-1:0]    cur_len   = '0;
    int                   lines_made;
    int                   line_run;
    int                   words_sent;
    bit                   tx_burst;

    // Receiver state
    int                   hold_left;
    int                   results_taken;
    bit                   rx_steady;

    int                   cycle_count;

    always #(HALF_PERIOD) clk = ~clk;

    line_substring_filter i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    line_substring_filter_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Stop a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[line_substring_filter] ERROR");
            $finish;
        end
    end

    // Result side: after each accepted word, drop ready for a drawn number of cycles.
    // Alternate between stretches of random stalls and stretches of none, and once
    // hold off long enough for the output register to fill and back up the input.
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left = 0;
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                results_taken++;
                if (results_taken % 24 == 0)
                    rx_steady = !rx_steady;
                if (results_taken == HOLD_AT_RESULT)
                    hold_left = LONG_HOLD_CYCLES;
                else
                    hold_left = rx_steady ? 0 : $urandom_range(0, 9);
            end else if (hold_left > 0) begin
                hold_left--;
            end
            out_ready <= (hold_left == 0);
        end
    end

    // Offer one text word after a drawn gap and hold it until accepted. Track line ends
    // the same way the block does so the ending can aim at the line limit.
    task automatic send_word(logic [7:0] c, logic eoi);
        t_in_word w;
        int       gap;
        w.char_byte    = c;
        w.end_of_input = eoi;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        repeat (gap) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
        words_sent++;
        if (!eoi) begin
            if (c == NEWLINE_BYTE) begin
                lines_made++;
                line_run = 0;
            end else begin
                line_run++;
                if (line_run == LINE_LENGTH_DEF) begin
                    lines_made++;
                    line_run = 0;
                end
            end
        end
    endtask

    // Favor bytes of the current pattern and a tiny alphabet so partial and
    // overlapping matches are common; keep newlines out of line text.
    function automatic logic [7:0] pick_text_byte();
        int         eff;
        int         idx;
        logic [7:0] b;
        eff = (cur_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(cur_len);
        case ($urandom_range(0, 3))
            0, 1: begin
                if (eff > 0) begin
                    idx = $urandom_range(0, eff - 1);
                    b   = cur_pat[8*idx +: 8];
                end else begin
                    b = 8'($urandom_range(0, 255));
                end
            end
            2: b = 8'h61 + 8'($urandom_range(0, 2));
            default: b = 8'($urandom_range(0, 255));
        endcase
        if (b == NEWLINE_BYTE)
            b = 8'h20;
        return b;
    endfunction

    function automatic logic [PAT_W-1:0] alphabet_pattern();
        logic [PAT_W-1:0] p;
        for (int k = 0; k < 8; k++)
            p[8*k +: 8] = 8'h61 + 8'($urandom_range(0, 2));
        return p;
    endfunction

    // Send one newline-ended line; optionally plant the pattern, sometimes with its
    // last byte flipped to make a near miss.
    task automatic send_line(int len, bit plant);
        logic [7:0] text [0:319];
        int         eff;
        int         at;
        eff = (cur_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(cur_len);
        for (int i = 0; i < len; i++)
            text[i] = pick_text_byte();
        if (plant && eff > 0 && len >= eff) begin
            at = $urandom_range(0, len - eff);
            for (int k = 0; k < eff; k++)
                text[at+k] = cur_pat[8*k +: 8];
            if ($urandom_range(0, 3) == 0)
                text[at+eff-1] = text[at+eff-1] ^ 8'h01;
        end
        tx_burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
            send_word(text[i], 1'b0);
        send_word(NEWLINE_BYTE, 1'b0);
    endtask

    // Raw bytes over the whole range, newlines included, no forced line end.
    task automatic send_noise(int len);
        tx_burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
            send_word(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Drop valid, wait until every report is in, then give the block time to
    // finish a word that reports nothing.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PAT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Load a new pattern while idle. Junk goes in the unused upper bits of the
    // length word and, on request, into the spare indexes.
    task automatic configure(logic [PAT_W-1:0] pat, logic [PLEN_W-1:0] len, bit spare);
        logic [PAT_W-1:0] d;
        wait_idle();
        d = {$urandom(), $urandom()};
        d[PLEN_W-1:0] = len;
        write_reg(REG_PATTERN_BYTES, pat);
        write_reg(REG_PATTERN_LENGTH, d);
        if (spare) begin
            write_reg(REG_SPARE_LO, {$urandom(), $urandom()});
            write_reg(REG_SPARE_HI, {$urandom(), $urandom()});
        end
        cfg_valid <= 1'b0;
        cur_pat = pat;
        cur_len = len;
    endtask

    initial begin : stimulus
        logic [PAT_W-1:0]  pat;
        logic [PLEN_W-1:0] len;
        int                target;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset pattern (zero length): an empty line, then zero bytes that must not match.
        send_word(NEWLINE_BYTE, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(NEWLINE_BYTE, 1'b0);

        // Two-byte pattern 00 FF: a hit, the same bytes split by a newline, and reversed.
        configure(64'h0000_0000_0000_FF00, 4'd2, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(NEWLINE_BYTE, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(NEWLINE_BYTE, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(NEWLINE_BYTE, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(NEWLINE_BYTE, 1'b0);

        // All-ones pattern with the length past the maximum: eight bytes must hit.
        configure('1, 4'd15, 1'b1);
        repeat (8) send_word(8'hFF, 1'b0);
        send_word(NEWLINE_BYTE, 1'b0);

        // Random phases, one pattern each; two of them carry a line at the length edge.
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin
                    pat = alphabet_pattern();
                    len = 4'd1;
                end
                1: begin
                    pat = '0;
                    len = 4'd3;
                end
                2: begin
                    pat = alphabet_pattern();
                    len = 4'($urandom_range(9, 15));
                end
                3: begin
                    pat = {$urandom(), $urandom()};
                    len = 4'd0;
                end
                default: begin
                    pat = ($urandom_range(0, 1) == 0) ? alphabet_pattern()
                                                       : {$urandom(), $urandom()};
                    len = 4'($urandom_range(1, 8));
                end
            endcase
            configure(pat, len, p == 2);
            if (p == 1)
                send_line(LINE_LENGTH_DEF - 1, 1'b1);
            if (p == 4)
                send_line($urandom_range(LINE_LENGTH_DEF, LINE_LENGTH_DEF + 40), 1'b1);
            target = words_sent + WORDS_PER_PHASE;
            while (words_sent < target) begin
                if ($urandom_range(0, 6) == 0)
                    send_noise($urandom_range(1, 10));
                else
                    send_line($urandom_range(0, 12), 1'($urandom_range(0, 1)));
            end
        end

        // Finish either at the line limit or with end of input after a partial line.
        if ($urandom_range(0, 1) == 0) begin
            while (lines_made < MAX_LINES_DEF)
                send_line($urandom_range(0, 2), 1'b1);
        end else begin
            repeat ($urandom_range(0, 5))
                send_word(pick_text_byte(), 1'b0);
        end
        send_word(8'($urandom_range(0, 255)), 1'b1);

        // The block is stopped now: everything after must be taken silently.
        repeat (4)
            send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        send_word(NEWLINE_BYTE, 1'b0);

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("[line_substring_filter] OK");
        else
            $display("[line_substring_filter] ERROR");
        $finish;
    end

endmodule
